/* src/bba_pkg.sv */
// Package for the bitmap block allocator: shared constants, codes and control types.
`default_nettype none
package bba_pkg;

  // These are the default pool geometry values for the top-level parameters.
  localparam int unsigned ROW_BITS_DEF = 4;
  localparam int unsigned COLUMNS_DEF  = 16;

  // These are the field widths at the ports.
  localparam int unsigned BSIZE_W  = 13;
  localparam int unsigned BIDX_W   = 9;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned GIDX_W   = 8;
  localparam int unsigned OFFS_W   = 20;
  localparam int unsigned OCNT_W   = 9;

  localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST = 13'd64;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_DOUBLE  = 2'd2;
  localparam status_t ST_INVALID = 2'd3;

  // These are the operation kinds carried on the input user signal.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_SRCH = 3'b100
  } state_t;

  // These are the commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // latch the request and read the rows it needs
    logic eval;  // decide a free, a hint allocation or a full pool, or start a search
    logic srch;  // finish a search allocation from the row just read
  } cmd_t;

  // This is the status from the datapath to the controller.
  typedef struct packed {
    logic need_search;  // the allocation goes on to a row search
    logic hint_ok;      // the hint block can be granted at once
  } sts_t;

endpackage
`default_nettype wire

/* src/bba_datapath.sv */
// Datapath of the bitmap block allocator: row memory, hint, count and result registers.
`default_nettype none
module bba_datapath
  import bba_pkg::*;
#(
  parameter int unsigned ROW_BITS = ROW_BITS_DEF,
  parameter int unsigned COLUMNS  = COLUMNS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cmd_t                cmd,
  output sts_t                     sts,
  input  wire logic                in_action,
  input  wire logic [BIDX_W-1:0]   in_block_index,
  input  wire logic                cfg_wr_en,
  input  wire logic [BSIZE_W-1:0]  cfg_wr_data,
  output status_t                  res_status,
  output logic      [GIDX_W-1:0]   res_granted_index,
  output logic      [OFFS_W-1:0]   res_byte_offset,
  output logic      [OCNT_W-1:0]   res_occupied_count
);

  localparam int unsigned ROWS  = 2 ** ROW_BITS;
  localparam int unsigned CAP   = ROWS * COLUMNS;
  localparam int unsigned IDX_W = $clog2(CAP);
  localparam int unsigned COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned CNT_W = $clog2(CAP + 1);
  localparam int unsigned PROD_W = GIDX_W + BSIZE_W;

  // The occupancy bitmap is stored one row per word; a word holds every column of a row.
  logic [COLUMNS-1:0] mem [ROWS];
  logic [ROWS-1:0]    row_valid_r;
  logic [ROWS-1:0]    row_full_r;

  logic [COLUMNS-1:0] rd_a_r, rd_b_r;
  logic               rd_a_v_r, rd_b_v_r;
  logic [ROW_BITS-1:0] addr_a, addr_b;
  logic               rd_en;

  logic               act_r;
  logic [BIDX_W-1:0]  blk_r;
  logic [ROW_BITS-1:0] srch_row_r, srch_row_nxt;

  logic [IDX_W-1:0]   hint_r, hint_nxt;
  logic               hint_v_r, hint_v_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [BSIZE_W-1:0] bsize_r;

  logic               wr_en;
  logic [ROW_BITS-1:0] wr_row;
  logic [COLUMNS-1:0] wr_data;

  logic               res_ld;
  status_t            res_st;
  logic               res_grant;
  logic [IDX_W-1:0]   res_idx;
  logic [GIDX_W-1:0]  gidx_val;
  logic [PROD_W-1:0]  prod;

  logic [COLUMNS-1:0] row_a, row_b;
  logic [ROW_BITS-1:0] hint_row, blk_row, next_row, in_blk_row;
  logic [COL_W-1:0]   hint_col, blk_col, next_col, free_col;
  logic [IDX_W:0]     next_idx;
  logic               hint_in_range, hint_ok, blk_in_range, any_free_row;
  logic [ROW_BITS-1:0] first_row;

  assign row_a = rd_a_v_r ? rd_a_r : '0;
  assign row_b = rd_b_v_r ? rd_b_r : '0;

  assign hint_row = hint_r[ROW_BITS-1:0];
  assign hint_col = COL_W'(hint_r >> ROW_BITS);
  assign next_idx = (IDX_W+1)'(hint_r) + (IDX_W+1)'(1);
  assign next_row = next_idx[ROW_BITS-1:0];
  assign next_col = COL_W'(next_idx >> ROW_BITS);
  assign blk_row  = blk_r[ROW_BITS-1:0];
  assign blk_col  = COL_W'(blk_r >> ROW_BITS);
  assign in_blk_row = in_block_index[ROW_BITS-1:0];

  assign hint_in_range = (IDX_W+1)'(hint_r) < (IDX_W+1)'(CAP);
  assign blk_in_range  = 32'(blk_r) < CAP;
  assign hint_ok       = hint_v_r && hint_in_range && !row_a[hint_col];
  assign any_free_row  = !(&row_full_r);

  // The search order puts rows outermost, so the first row that is not full holds the target.
  always_comb begin
    first_row = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (!row_full_r[r]) first_row = ROW_BITS'(r);
    end
  end

  always_comb begin
    free_col = '0;
    for (int c = COLUMNS - 1; c >= 0; c--) begin
      if (!row_a[c]) free_col = COL_W'(c);
    end
  end

  assign sts.need_search = (act_r == ACT_ALLOC) && !hint_ok && any_free_row;
  assign sts.hint_ok     = hint_ok;

  // The read addresses come from the request's block or the hint while it is latched, or from the search row.
  always_comb begin
    rd_en  = cmd.load || (cmd.eval && sts.need_search);
    addr_a = (in_action == ACT_FREE) ? in_blk_row : hint_row;
    addr_b = next_row;
    if (cmd.eval) addr_a = first_row;
  end

  always_comb begin
    wr_en        = 1'b0;
    wr_row       = hint_row;
    wr_data      = row_a;
    hint_nxt     = hint_r;
    hint_v_nxt   = hint_v_r;
    cnt_nxt      = cnt_r;
    res_ld       = 1'b0;
    res_st       = ST_OK;
    res_grant    = 1'b0;
    res_idx      = hint_r;
    srch_row_nxt = srch_row_r;
    if (cmd.eval) begin
      if (act_r == ACT_FREE) begin
        res_ld = 1'b1;
        if (!blk_in_range) begin
          res_st = ST_INVALID;
        end else if (!row_a[blk_col]) begin
          res_st = ST_DOUBLE;
        end else begin
          wr_en          = 1'b1;
          wr_row         = blk_row;
          wr_data        = row_a;
          wr_data[blk_col] = 1'b0;
          if (cnt_r != '0) cnt_nxt = cnt_r - CNT_W'(1);
          hint_nxt       = IDX_W'(blk_r);
          hint_v_nxt     = 1'b1;
        end
      end else if (hint_ok) begin
        res_ld    = 1'b1;
        res_grant = 1'b1;
        wr_en     = 1'b1;
        wr_row    = hint_row;
        wr_data   = row_a;
        wr_data[hint_col] = 1'b1;
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (next_idx >= (IDX_W+1)'(CAP) || row_b[next_col]) begin
          hint_v_nxt = 1'b0;
        end else begin
          hint_nxt = IDX_W'(next_idx);
        end
      end else if (!any_free_row) begin
        res_ld = 1'b1;
        res_st = ST_FULL;
      end else begin
        srch_row_nxt = first_row;
      end
    end else if (cmd.srch) begin
      res_ld    = 1'b1;
      res_grant = 1'b1;
      res_idx   = IDX_W'({free_col, srch_row_r});
      wr_en     = 1'b1;
      wr_row    = srch_row_r;
      wr_data   = row_a;
      wr_data[free_col] = 1'b1;
      cnt_nxt   = cnt_r + CNT_W'(1);
    end
  end

  assign gidx_val = res_grant ? GIDX_W'(res_idx) : '0;
  assign prod     = gidx_val * bsize_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_row] <= wr_data;
    if (rd_en) begin
      rd_a_r   <= mem[addr_a];
      rd_b_r   <= mem[addr_b];
      rd_a_v_r <= row_valid_r[addr_a];
      rd_b_v_r <= row_valid_r[addr_b];
    end
    if (cmd.load) begin
      act_r <= in_action;
      blk_r <= in_block_index;
    end
    srch_row_r <= srch_row_nxt;
    if (res_ld) begin
      res_status         <= res_st;
      res_granted_index  <= gidx_val;
      res_byte_offset    <= prod[OFFS_W-1:0];
      res_occupied_count <= OCNT_W'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      row_full_r  <= '0;
      hint_r      <= '0;
      hint_v_r    <= 1'b1;
      cnt_r       <= '0;
      bsize_r     <= BLOCK_SIZE_RST;
    end else begin
      if (wr_en) begin
        row_valid_r[wr_row] <= 1'b1;
        row_full_r[wr_row]  <= &wr_data;
      end
      hint_r   <= hint_nxt;
      hint_v_r <= hint_v_nxt;
      cnt_r    <= cnt_nxt;
      if (cfg_wr_en) bsize_r <= cfg_wr_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= CAP)
    else $error("occupied count exceeds the pool capacity");

  a_hint_range: assert property (@(posedge clk) disable iff (!rst_n)
    hint_v_r |-> hint_in_range)
    else $error("valid hint points past the pool");

  a_srch_row: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.srch |-> !row_full_r[srch_row_r])
    else $error("search landed on a full row");

endmodule
`default_nettype wire

/* src/bba_ctrl.sv */
// Controller of the bitmap block allocator: request sequencing and output handshake.
`default_nettype none
module bba_ctrl
  import bba_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  wire logic out_tready,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   res_done;

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;

  assign cmd.load = in_tvalid && in_tready;
  assign cmd.eval = (state_r == S_EVAL);
  assign cmd.srch = (state_r == S_SRCH);

  assign res_done = (cmd.eval && !sts.need_search) || cmd.srch;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (cmd.load) state_nxt = S_EVAL;
      S_EVAL:  state_nxt = sts.need_search ? S_SRCH : S_IDLE;
      S_SRCH:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (res_done) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_search_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.eval && sts.need_search) |=> cmd.srch)
    else $error("search step did not follow a missed hint");

  a_hint_no_search: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.eval && sts.hint_ok) |=> (out_valid_r && state_r == S_IDLE))
    else $error("hint grant did not produce a result");

endmodule
`default_nettype wire

/* src/bitmap_block_allocator_top.sv */
// Top level of the bitmap block allocator: stream ports, controller and datapath.
// A free, a hinted allocate or a full report is decided in the evaluate state, from the
// registered row read made at the input transfer, and loaded into the output register.
// A new request is taken only in the idle state, once the last is decided, and only while
// the output register is empty or being read; a row search adds one more row read.
// Reset (rst_n, synchronous, active low) marks every row of the bitmap as never written,
// so all blocks read as free at once with no clearing pass; hint 0 valid, count 0, size 64.
`default_nettype none
module bitmap_block_allocator_top
  import bba_pkg::*;
#(
  parameter int unsigned ROW_BITS = ROW_BITS_DEF,
  parameter int unsigned COLUMNS  = COLUMNS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Input stream: one allocate or free request per transfer.
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [15:0]        in_tdata,   // [8:0] block_index, [15:9] zero
  input  wire logic               in_tuser,   // [0] action (0 allocate, 1 free)
  // Result stream: one result per request.
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic      [39:0]        out_tdata,  // [1:0] status, [9:2] granted_index,
                                              // [29:10] byte_offset,
                                              // [38:30] occupied_count, [39] zero
  // Block size register; the user must write it only while no request is in flight, the block does not enforce it.
  input  wire logic               cfg_wr_en,
  input  wire logic [BSIZE_W-1:0] cfg_wr_data
);

  cmd_t               cmd;
  sts_t               sts;
  status_t            res_status;
  logic [GIDX_W-1:0]  res_granted_index;
  logic [OFFS_W-1:0]  res_byte_offset;
  logic [OCNT_W-1:0]  res_occupied_count;

  // The controller sequences each request and owns both handshakes.
  bba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // The datapath holds the bitmap rows, the hint, the count and the result register,
  // which keeps a finished result stable until the downstream side takes it.
  bba_datapath #(
    .ROW_BITS (ROW_BITS),
    .COLUMNS  (COLUMNS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_action          (in_tuser),
    .in_block_index     (in_tdata[BIDX_W-1:0]),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .res_status         (res_status),
    .res_granted_index  (res_granted_index),
    .res_byte_offset    (res_byte_offset),
    .res_occupied_count (res_occupied_count)
  );

  assign out_tdata = {1'b0, res_occupied_count, res_byte_offset, res_granted_index,
                      res_status};

endmodule
`default_nettype wire
